[sv/bitmap_page_frame_allocator_defines.svh]
// Assertion macros for the bitmap page frame allocator.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BPFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define BPFA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define BPFA_ASSERT(label, prop, msg)
`define BPFA_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[sv/bpfa_pkg.sv]
// Shared constants, types and codes of the bitmap page frame allocator.
package bpfa_pkg;

    localparam int PAGE_COUNT    = 1024;
    localparam int PAGE_SHIFT    = 12;
    localparam int ADDR_W        = 32;
    localparam int COUNT_FIELD_W = 11;
    localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0010_0000;

    localparam int WORD_W      = (PAGE_COUNT < 32) ? PAGE_COUNT : 32;
    localparam int WORD_COUNT  = PAGE_COUNT / WORD_W;
    localparam int BIT_IDX_W   = $clog2(WORD_W);
    localparam int WORD_IDX_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int PAGE_IDX_W  = $clog2(PAGE_COUNT);
    localparam int COUNT_W     = $clog2(PAGE_COUNT + 1);

    typedef enum logic [1:0] {
        STAT_ALLOCATED = 2'd0,
        STAT_NO_PAGE   = 2'd1,
        STAT_FREED     = 2'd2,
        STAT_RANGE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

[sv/bpfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bpfa_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 32
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [DATA_W-1:0]                         wr_data,
    input  logic                                      rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [DATA_W-1:0]                         rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/bpfa_ctrl.sv]
// Controller state machine: sequences lookup and read-modify-write per request.
module bpfa_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  bpfa_pkg::stat_t stat,
    output bpfa_pkg::cmd_t  cmd
);
    import bpfa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/bpfa_dpath.sv]
// Datapath: bitmap RAM, full-word summary, counts, base register and result register.
`include "bitmap_page_frame_allocator_defines.svh"
module bpfa_dpath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bpfa_pkg::cmd_t                    cmd,
    output bpfa_pkg::stat_t                   stat,
    input  logic                              s_operation,
    input  logic [bpfa_pkg::ADDR_W-1:0]       s_address,
    input  logic                              cfg_valid,
    input  logic [bpfa_pkg::ADDR_W-1:0]       cfg_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bpfa_pkg::ADDR_W-1:0]       m_page_address,
    output logic [1:0]                        m_status,
    output logic [bpfa_pkg::COUNT_FIELD_W-1:0] m_used_pages,
    output logic [bpfa_pkg::COUNT_FIELD_W-1:0] m_free_pages
);
    import bpfa_pkg::*;

    logic [ADDR_W-1:0]     base_reg;
    logic                  op_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [WORD_COUNT-1:0] full_reg;
    logic [WORD_COUNT-1:0] row_valid_reg;
    logic [COUNT_W-1:0]    used_reg;
    logic [COUNT_W-1:0]    used_next;
    logic [WORD_IDX_W-1:0] word_idx_reg;
    logic [WORD_IDX_W-1:0] word_idx_next;
    logic [BIT_IDX_W-1:0]  bit_idx_reg;
    logic [BIT_IDX_W-1:0]  bit_idx_next;
    status_t               pend_reg;
    status_t               pend_next;

    logic                  m_valid_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic [ADDR_W-1:0]     out_addr_next;
    status_t               out_status_reg;

    logic                  word_found;
    logic [WORD_IDX_W-1:0] free_word;
    logic [ADDR_W-1:0]     offset;
    logic [ADDR_W-1:0]     offset_page;
    logic                  out_of_range;
    logic [PAGE_IDX_W-1:0] rel_page;

    logic [WORD_W-1:0]     ram_rdata;
    logic [WORD_W-1:0]     cur_word;
    logic [WORD_W-1:0]     new_word;
    logic [BIT_IDX_W-1:0]  alloc_bit;
    logic                  ram_we;
    logic [PAGE_IDX_W+PAGE_SHIFT-1:0] page_off;

    // lookup: first non-full word, or page index of the address to free
    always_comb begin
        word_found = 1'b0;
        free_word  = '0;
        for (int i = WORD_COUNT - 1; i >= 0; i--) begin
            if (!full_reg[i]) begin
                word_found = 1'b1;
                free_word  = WORD_IDX_W'(i);
            end
        end
    end

    assign offset       = addr_reg - base_reg;
    assign offset_page  = offset >> PAGE_SHIFT;
    assign out_of_range = (addr_reg < base_reg) || (offset_page >= ADDR_W'(PAGE_COUNT));
    assign rel_page     = offset_page[PAGE_IDX_W-1:0];

    always_comb begin
        if (!op_reg) begin
            word_idx_next = free_word;
            bit_idx_next  = '0;
            pend_next     = word_found ? STAT_ALLOCATED : STAT_NO_PAGE;
        end else begin
            word_idx_next = WORD_IDX_W'(rel_page >> BIT_IDX_W);
            bit_idx_next  = rel_page[BIT_IDX_W-1:0];
            pend_next     = out_of_range ? STAT_RANGE : STAT_FREED;
        end
    end

    bpfa_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (WORD_COUNT)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (word_idx_reg),
        .wr_data (new_word),
        .rd_en   (cmd.lookup),
        .rd_addr (word_idx_next),
        .rd_data (ram_rdata)
    );

    // update: read-modify-write of the selected bitmap word
    assign cur_word = row_valid_reg[word_idx_reg] ? ram_rdata : '0;

    always_comb begin
        alloc_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!cur_word[i]) begin
                alloc_bit = BIT_IDX_W'(i);
            end
        end
    end

    assign page_off = {word_idx_reg, alloc_bit, {PAGE_SHIFT{1'b0}}};

    always_comb begin
        new_word      = cur_word;
        ram_we        = 1'b0;
        used_next     = used_reg;
        out_addr_next = '0;
        case (pend_reg)
            STAT_ALLOCATED: begin
                new_word[alloc_bit] = 1'b1;
                ram_we              = cmd.load_out;
                used_next           = used_reg + COUNT_W'(1);
                out_addr_next       = base_reg + ADDR_W'(page_off);
            end
            STAT_FREED: begin
                new_word[bit_idx_reg] = 1'b0;
                ram_we                = cmd.load_out && cur_word[bit_idx_reg];
                if (cur_word[bit_idx_reg]) begin
                    used_next = used_reg - COUNT_W'(1);
                end
            end
            default: begin
                new_word = cur_word;
            end
        endcase
    end

    assign stat.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= BASE_RESET;
            full_reg      <= '0;
            row_valid_reg <= '0;
            used_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                base_reg <= cfg_data;
            end
            if (ram_we) begin
                row_valid_reg[word_idx_reg] <= 1'b1;
                full_reg[word_idx_reg]      <= &new_word;
            end
            if (cmd.load_out) begin
                used_reg    <= used_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_operation;
            addr_reg <= s_address;
        end
        if (cmd.lookup) begin
            word_idx_reg <= word_idx_next;
            bit_idx_reg  <= bit_idx_next;
            pend_reg     <= pend_next;
        end
        if (cmd.load_out) begin
            out_addr_reg   <= out_addr_next;
            out_status_reg <= pend_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_page_address = out_addr_reg;
    assign m_status       = out_status_reg;
    assign m_used_pages   = COUNT_FIELD_W'(used_reg);
    assign m_free_pages   = COUNT_FIELD_W'(COUNT_W'(PAGE_COUNT) - used_reg);

    `BPFA_ASSERT(a_used_bound, used_reg <= COUNT_W'(PAGE_COUNT), "used count above page count")
    `BPFA_ASSERT(a_full_rows_written, (full_reg & ~row_valid_reg) == '0,
        "full summary set on unwritten row")
    `BPFA_ASSERT(a_no_page_only_when_full,
        (cmd.load_out && pend_reg == STAT_NO_PAGE) |-> (used_reg == COUNT_W'(PAGE_COUNT)),
        "out of pages reported with free pages left")
    `BPFA_ASSERT(a_alloc_counts,
        (cmd.load_out && pend_reg == STAT_ALLOCATED) |=> (used_reg == $past(used_reg) + 1'b1),
        "allocate did not raise used count")
    `BPFA_ASSERT(a_alloc_bit_free, (cmd.load_out && pend_reg == STAT_ALLOCATED) |-> !(&cur_word),
        "allocate on a full word")

endmodule

[sv/bitmap_page_frame_allocator.sv]
// Top level of the bitmap first-fit page frame allocator.
// One request is in flight at a time. It passes an accepting state, a lookup
// state that picks the lowest non-full bitmap word from a per-word full
// summary (or forms the page index of a free) and reads that word from the
// 32 x 32 bitmap RAM, and an update state that waits for a free result
// register, writes the word back and loads the result register. The next
// request is accepted in the cycle after the result is loaded, while that
// result may still wait for transfer. The bitmap reads as all free after
// reset through per-word valid bits, so no clearing pass is needed.
// cfg_valid writes base_address (cfg_ready is always high), even mid-request.
module bitmap_page_frame_allocator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpfa_pkg::ADDR_W-1:0]        cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_operation,
    input  logic [bpfa_pkg::ADDR_W-1:0]        s_address,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bpfa_pkg::ADDR_W-1:0]        m_page_address,
    output logic [1:0]                         m_status,
    output logic [bpfa_pkg::COUNT_FIELD_W-1:0] m_used_pages,
    output logic [bpfa_pkg::COUNT_FIELD_W-1:0] m_free_pages
);
    import bpfa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    bpfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bpfa_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_operation    (s_operation),
        .s_address      (s_address),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_page_address (m_page_address),
        .m_status       (m_status),
        .m_used_pages   (m_used_pages),
        .m_free_pages   (m_free_pages)
    );

endmodule

[dv/tb_bitmap_page_frame_allocator.sv]
// Testbench for the bitmap first-fit page frame allocator, checked against a local model.
`timescale 1ns / 100ps

module tb_bitmap_page_frame_allocator;
    import bpfa_pkg::*;

    localparam int          CLK_PERIOD  = 8;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_WAIT  = 6;
    localparam logic        OP_ALLOC    = 1'b0;
    localparam logic        OP_FREE     = 1'b1;
    localparam logic [31:0] PAGE_BYTES  = 32'd1 << PAGE_SHIFT;
    localparam logic [31:0] BASE_TOP    = 32'hFFC0_0000;

    typedef struct packed {
        logic [ADDR_W-1:0]        page_address;
        status_t                  status;
        logic [COUNT_FIELD_W-1:0] used_cnt;
        logic [COUNT_FIELD_W-1:0] free_cnt;
    } page_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [ADDR_W-1:0]        cfg_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_operation = OP_ALLOC;
    logic [ADDR_W-1:0]        s_address = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [ADDR_W-1:0]        m_page_address;
    logic [1:0]               m_status;
    logic [COUNT_FIELD_W-1:0] m_used_pages;
    logic [COUNT_FIELD_W-1:0] m_free_pages;

    // model state
    bit                page_used [PAGE_COUNT];
    int                used_total = 0;
    logic [ADDR_W-1:0] base_addr = BASE_RESET;

    page_result_t      pending_results[$];
    int                error_count = 0;
    int                request_count = 0;
    int                result_count = 0;
    int                base_writes = 0;
    int                cycle_count = 0;
    bit                idle_off = 1'b0;

    bitmap_page_frame_allocator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_address      (s_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_page_address (m_page_address),
        .m_status       (m_status),
        .m_used_pages   (m_used_pages),
        .m_free_pages   (m_free_pages)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("tb_bitmap_page_frame_allocator: done, errors");
            $finish;
        end
    end

    function automatic int unsigned draw_idle();
        if (idle_off)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    function automatic page_result_t predict_page_op(input logic op, input logic [31:0] addr);
        page_result_t r;
        int           idx;
        logic [31:0]  offset;
        r.page_address = '0;
        if (op == OP_ALLOC) begin
            r.status = STAT_NO_PAGE;
            idx = 0;
            while (idx < PAGE_COUNT && page_used[idx])
                idx++;
            if (idx < PAGE_COUNT) begin
                page_used[idx] = 1'b1;
                used_total++;
                r.page_address = base_addr + (32'(idx) << PAGE_SHIFT);
                r.status = STAT_ALLOCATED;
            end
        end else if (addr < base_addr) begin
            r.status = STAT_RANGE;
        end else begin
            offset = addr - base_addr;
            if ((offset >> PAGE_SHIFT) >= PAGE_COUNT) begin
                r.status = STAT_RANGE;
            end else begin
                idx = int'(offset >> PAGE_SHIFT);
                if (page_used[idx]) begin
                    page_used[idx] = 1'b0;
                    used_total--;
                end
                r.status = STAT_FREED;
            end
        end
        r.used_cnt = COUNT_FIELD_W'(used_total);
        r.free_cnt = COUNT_FIELD_W'(PAGE_COUNT - used_total);
        return r;
    endfunction

    function automatic int find_used_page(input int start);
        int i;
        for (i = 0; i < PAGE_COUNT; i++)
            if (page_used[(start + i) % PAGE_COUNT])
                return (start + i) % PAGE_COUNT;
        return -1;
    endfunction

    function automatic logic [31:0] page_start(input int idx);
        return base_addr + (32'(idx) << PAGE_SHIFT);
    endfunction

    function automatic logic [31:0] pick_free_address();
        int unsigned sel;
        int          idx;
        logic [31:0] in_page;
        sel = $urandom_range(0, 99);
        in_page = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, PAGE_BYTES - 1));
        if (sel < 55) begin
            idx = find_used_page($urandom_range(0, PAGE_COUNT - 1));
            if (idx < 0)
                idx = $urandom_range(0, PAGE_COUNT - 1);
            return page_start(idx) + in_page;
        end
        if (sel < 70)
            return page_start($urandom_range(0, PAGE_COUNT - 1)) + in_page;
        if (sel < 80)
            return base_addr - 32'($urandom_range(1, 16));
        if (sel < 90)
            return page_start(PAGE_COUNT) + 32'($urandom_range(0, 2 * PAGE_BYTES));
        return $urandom();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin : check_result
        page_result_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending", m_page_address, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_page_address !== want.page_address)
                    report_mismatch("page_address", m_page_address, want.page_address);
                if (m_status !== want.status)
                    report_mismatch("status", 32'(m_status), 32'(want.status));
                if (m_used_pages !== want.used_cnt)
                    report_mismatch("used count", 32'(m_used_pages), 32'(want.used_cnt));
                if (m_free_pages !== want.free_cnt)
                    report_mismatch("free count", 32'(m_free_pages), 32'(want.free_cnt));
            end
        end
    end

    initial begin : result_ready
        int unsigned stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = draw_idle();
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_page_request(input logic op, input logic [31:0] addr);
        int unsigned gap;
        gap = draw_idle();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_address   <= addr;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_page_op(op, addr));
        request_count++;
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_base_address(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        base_addr = value;
        base_writes++;
    endtask

    // runs at the reset base: empty map, corner addresses, double free
    task automatic test_directed_cases();
        send_page_request(OP_FREE, base_addr);
        send_page_request(OP_ALLOC, 32'h0000_0000);
        send_page_request(OP_ALLOC, 32'hFFFF_FFFF);
        send_page_request(OP_ALLOC, 32'h5555_5555);
        send_page_request(OP_ALLOC, 32'hAAAA_AAAA);
        send_page_request(OP_FREE, page_start(1));
        send_page_request(OP_ALLOC, 32'h0);
        send_page_request(OP_FREE, page_start(2) + 32'h0000_0ABC);
        send_page_request(OP_FREE, page_start(2));
        send_page_request(OP_FREE, base_addr - 32'd1);
        send_page_request(OP_FREE, 32'h0000_0000);
        send_page_request(OP_FREE, page_start(PAGE_COUNT));
        send_page_request(OP_FREE, 32'hFFFF_FFFF);
        send_page_request(OP_FREE, page_start(PAGE_COUNT) - 32'd1);
        send_page_request(OP_ALLOC, 32'h0);
        send_page_request(OP_FREE, page_start(0));
        send_page_request(OP_FREE, page_start(1) + PAGE_BYTES - 32'd1);
        send_page_request(OP_FREE, page_start(3));
        send_page_request(OP_FREE, page_start(2));
        send_page_request(OP_ALLOC, 32'h0);
        send_page_request(OP_FREE, page_start(0) + 32'd1);
    endtask

    // fill every frame at base zero, then run out of pages
    task automatic test_fill_to_exhaustion();
        int i;
        wait_results_drained();
        write_base_address(32'h0000_0000);
        for (i = 0; i < PAGE_COUNT + 4; i++)
            send_page_request(OP_ALLOC, $urandom());
    endtask

    task automatic test_random_mix(input logic [31:0] base, input int unsigned alloc_pct,
                                   input int count, input bit no_idle);
        int i;
        wait_results_drained();
        write_base_address(base);
        idle_off = no_idle;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < alloc_pct)
                send_page_request(OP_ALLOC, $urandom());
            else
                send_page_request(OP_FREE, pick_free_address());
        end
        idle_off = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_fill_to_exhaustion();
        test_random_mix(BASE_TOP, 30, 125, 1'b0);
        test_random_mix(32'($urandom_range(0, BASE_TOP)), 60, 125, 1'b0);
        test_random_mix(BASE_RESET, 50, 125, 1'b1);
        test_random_mix(32'($urandom_range(0, BASE_TOP >> PAGE_SHIFT)) << PAGE_SHIFT,
                        20, 125, 1'b0);
        wait_results_drained();
        $display("allocate/free run: %0d requests over %0d base settings, %0d results checked",
                 request_count, base_writes, result_count);
        $display("covered empty and full bitmap, double free, unaligned and out-of-range frees");
        if (error_count == 0)
            $display("tb_bitmap_page_frame_allocator: done, clean");
        else
            $display("tb_bitmap_page_frame_allocator: done, errors");
        $finish;
    end

endmodule
